/* rtl/ktsub_pkg.sv */
`timescale 1ns / 1ps

package ktsub_pkg;

  // Alphabet and cube geometry.
  localparam int SYM_COUNT = 27;
  localparam int SYM_W     = 5;
  localparam int CODE_W    = 5;
  localparam int TRIT_W    = 2;
  localparam int KIND_W    = 3;

  localparam logic [SYM_W-1:0] LAST_SYM  = 5'd26;
  localparam logic [SYM_W-1:0] FULL_FILL = 5'd27;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEY     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END_KEY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ENCODE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DECODE  = 3'd4;

  // Result kinds.
  localparam logic RES_ENCODE = 1'b0;
  localparam logic RES_DECODE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             restart;
    logic             key_place;
    logic             fill_place;
    logic             fill_finish;
    logic             load_enc;
    logic             load_dec;
    logic [SYM_W-1:0] fill_index;
  } cmd_t;

  typedef struct packed {
    logic [TRIT_W-1:0] hi;
    logic [TRIT_W-1:0] mid;
    logic [TRIT_W-1:0] lo;
  } trits_t;

  // Residue mod 3 of a 5-bit code: bit weights alternate 1, 2, 1, 2, 1.
  function automatic logic [TRIT_W-1:0] mod3(input logic [CODE_W-1:0] v);
    logic [2:0] s;
    s = {2'b00, v[0]} + {2'b00, v[2]} + {2'b00, v[4]}
      + {1'b0, v[1], 1'b0} + {1'b0, v[3], 1'b0};
    if (s >= 3'd6) begin
      s = s - 3'd6;
    end else if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  // Split a cube position (0..26) into its three base-3 digits.
  function automatic trits_t pos_to_trits(input logic [SYM_W-1:0] p);
    logic [SYM_W-1:0] r;
    trits_t           t;
    if (p >= 5'd18) begin
      t.hi = 2'd2;
      r    = p - 5'd18;
    end else if (p >= 5'd9) begin
      t.hi = 2'd1;
      r    = p - 5'd9;
    end else begin
      t.hi = 2'd0;
      r    = p;
    end
    if (r >= 5'd6) begin
      t.mid = 2'd2;
      r     = r - 5'd6;
    end else if (r >= 5'd3) begin
      t.mid = 2'd1;
      r     = r - 5'd3;
    end else begin
      t.mid = 2'd0;
    end
    t.lo = r[1:0];
    return t;
  endfunction

  // Form a cube position from three base-3 digits: hi*9 + mid*3 + lo.
  function automatic logic [SYM_W-1:0] trits_to_pos(input trits_t t);
    return {t.hi, 3'b000} + {3'b000, t.hi} + {2'b00, t.mid, 1'b0}
         + {3'b000, t.mid} + {3'b000, t.lo};
  endfunction

endpackage

/* rtl/ktsub_ctrl.sv */
`timescale 1ns / 1ps

module ktsub_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ktsub_pkg::KIND_W-1:0]      in_kind,
  input  logic [ktsub_pkg::SYM_W-1:0]       in_symbol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ktsub_pkg::cmd_t                   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FILL = 1'b1;

  logic                          state_r, state_nxt;
  logic [ktsub_pkg::SYM_W-1:0]   fill_idx_r, fill_idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          accept;
  logic                          sym_ok;
  logic                          load;

  // Take a beat only in idle and only when the output register can be refilled.
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign sym_ok    = in_symbol <= ktsub_pkg::LAST_SYM;
  assign out_valid = out_valid_r;

  // Commands for the datapath.
  always_comb begin
    cmd             = '0;
    cmd.fill_index  = fill_idx_r;
    if (accept) begin
      case (in_kind)
        ktsub_pkg::KIND_RESTART: cmd.restart   = 1'b1;
        ktsub_pkg::KIND_KEY:     cmd.key_place = 1'b1;
        ktsub_pkg::KIND_ENCODE:  cmd.load_enc  = sym_ok;
        ktsub_pkg::KIND_DECODE:  cmd.load_dec  = 1'b1;
        default:                 cmd.restart   = 1'b0;
      endcase
    end
    if (state_r == ST_FILL) begin
      cmd.fill_place  = 1'b1;
      cmd.fill_finish = (fill_idx_r == ktsub_pkg::LAST_SYM);
    end
  end

  assign load = cmd.load_enc || cmd.load_dec;

  // Sequencer: end key walks all symbols, one a cycle.
  always_comb begin
    state_nxt    = state_r;
    fill_idx_nxt = fill_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == ktsub_pkg::KIND_END_KEY)) begin
          state_nxt    = ST_FILL;
          fill_idx_nxt = '0;
        end
      end
      ST_FILL: begin
        if (fill_idx_r == ktsub_pkg::LAST_SYM) begin
          state_nxt = ST_IDLE;
        end else begin
          fill_idx_nxt = fill_idx_r + 5'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output beat valid flag.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_idx_r  <= fill_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No input beat is taken while the fill sequence runs.
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !in_ready)
    else $error("input beat taken during key fill");

  // A pending result is never dropped before it is taken.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");

  // The fill index stays inside the alphabet.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (fill_idx_r <= ktsub_pkg::LAST_SYM))
    else $error("fill index out of range");

  // The fill sequence ends after the last symbol.
  a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FILL) && (fill_idx_r == ktsub_pkg::LAST_SYM)) |=> (state_r == ST_IDLE))
    else $error("fill sequence did not end");

endmodule

/* rtl/ktsub_datapath.sv */
`timescale 1ns / 1ps

module ktsub_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ktsub_pkg::cmd_t                   cmd,
  input  logic [ktsub_pkg::SYM_W-1:0]       in_symbol,
  input  logic [ktsub_pkg::CODE_W-1:0]      in_code_high,
  input  logic [ktsub_pkg::CODE_W-1:0]      in_code_mid,
  input  logic [ktsub_pkg::CODE_W-1:0]      in_code_low,
  output logic                              out_result_kind,
  output logic [ktsub_pkg::TRIT_W-1:0]      out_trit_high,
  output logic [ktsub_pkg::TRIT_W-1:0]      out_trit_mid,
  output logic [ktsub_pkg::TRIT_W-1:0]      out_trit_low,
  output logic [ktsub_pkg::SYM_W-1:0]       out_plain_symbol
);

  logic [ktsub_pkg::SYM_W-1:0] cube_r  [0:ktsub_pkg::SYM_COUNT-1];
  logic [ktsub_pkg::SYM_W-1:0] pos_r   [0:ktsub_pkg::SYM_COUNT-1];
  logic [ktsub_pkg::SYM_COUNT-1:0] used_r;
  logic [ktsub_pkg::SYM_W-1:0] fill_cnt_r, fill_cnt_nxt;

  logic                          res_kind_r;
  ktsub_pkg::trits_t             trits_r;
  logic [ktsub_pkg::SYM_W-1:0]   plain_r;

  logic [ktsub_pkg::SYM_W-1:0]   place_sym;
  logic                          place_req;
  logic                          place_en;
  logic [ktsub_pkg::SYM_W-1:0]   enc_pos;
  ktsub_pkg::trits_t             enc_trits;
  ktsub_pkg::trits_t             dec_trits;
  logic [ktsub_pkg::SYM_W-1:0]   dec_pos;

  // Symbol placement: key beats use the input symbol, the fill walks the alphabet.
  assign place_sym = cmd.fill_place ? cmd.fill_index : in_symbol;
  assign place_req = cmd.fill_place || cmd.key_place;
  assign place_en  = place_req && (place_sym <= ktsub_pkg::LAST_SYM)
                  && !used_r[place_sym] && (fill_cnt_r < ktsub_pkg::FULL_FILL);

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    if (cmd.restart) begin
      fill_cnt_nxt = '0;
    end else if (cmd.fill_finish) begin
      fill_cnt_nxt = ktsub_pkg::FULL_FILL;
    end else if (place_en) begin
      fill_cnt_nxt = fill_cnt_r + 5'd1;
    end
  end

  // Keyed tables and used map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ktsub_pkg::SYM_COUNT; i++) begin
        cube_r[i] <= ktsub_pkg::SYM_W'(i);
        pos_r[i]  <= ktsub_pkg::SYM_W'(i);
      end
      used_r     <= '0;
      fill_cnt_r <= '0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
      if (cmd.restart) begin
        used_r <= '0;
      end else if (place_en) begin
        used_r[place_sym] <= 1'b1;
      end
      if (place_en) begin
        cube_r[fill_cnt_r] <= place_sym;
        pos_r[place_sym]   <= fill_cnt_r;
      end
    end
  end

  // Encode looks up the position, decode forms it from the reduced codes.
  assign enc_pos   = (in_symbol <= ktsub_pkg::LAST_SYM) ? pos_r[in_symbol] : '0;
  assign enc_trits = ktsub_pkg::pos_to_trits(enc_pos);
  assign dec_trits = '{hi:  ktsub_pkg::mod3(in_code_high),
                       mid: ktsub_pkg::mod3(in_code_mid),
                       lo:  ktsub_pkg::mod3(in_code_low)};
  assign dec_pos   = ktsub_pkg::trits_to_pos(dec_trits);

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (cmd.load_enc) begin
      res_kind_r <= ktsub_pkg::RES_ENCODE;
      trits_r    <= enc_trits;
      plain_r    <= '0;
    end else if (cmd.load_dec) begin
      res_kind_r <= ktsub_pkg::RES_DECODE;
      trits_r    <= '0;
      plain_r    <= cube_r[dec_pos];
    end
  end

  assign out_result_kind  = res_kind_r;
  assign out_trit_high    = trits_r.hi;
  assign out_trit_mid     = trits_r.mid;
  assign out_trit_low     = trits_r.lo;
  assign out_plain_symbol = plain_r;

endmodule

/* rtl/keyed_trifid_substitution_unit.sv */
`timescale 1ns / 1ps
// An encode beat with a symbol in 0..26, or a decode beat, gives its result in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken.
// An end-key beat runs the fill sequencer over all 27 symbols, one per cycle, so input
// is held off until the fill sequence ends.
// Reset is synchronous, active low: identity cube, empty used map, fill count zero.

module keyed_trifid_substitution_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ktsub_pkg::KIND_W-1:0]      in_kind,
  input  logic [ktsub_pkg::SYM_W-1:0]       in_symbol,
  input  logic [ktsub_pkg::CODE_W-1:0]      in_code_high,
  input  logic [ktsub_pkg::CODE_W-1:0]      in_code_mid,
  input  logic [ktsub_pkg::CODE_W-1:0]      in_code_low,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_kind,
  output logic [ktsub_pkg::TRIT_W-1:0]      out_trit_high,
  output logic [ktsub_pkg::TRIT_W-1:0]      out_trit_mid,
  output logic [ktsub_pkg::TRIT_W-1:0]      out_trit_low,
  output logic [ktsub_pkg::SYM_W-1:0]       out_plain_symbol
);

  ktsub_pkg::cmd_t cmd;

  // Controller: handshakes and the end-key fill sequencer.
  ktsub_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_symbol (in_symbol),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: keyed cube tables and the result register.
  ktsub_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_symbol        (in_symbol),
    .in_code_high     (in_code_high),
    .in_code_mid      (in_code_mid),
    .in_code_low      (in_code_low),
    .out_result_kind  (out_result_kind),
    .out_trit_high    (out_trit_high),
    .out_trit_mid     (out_trit_mid),
    .out_trit_low     (out_trit_low),
    .out_plain_symbol (out_plain_symbol)
  );

endmodule
